// ===== rtl/rvx_pkg.sv =====
// ----------------------------------------------------------------------------
// RV32IM execute unit package
// Shared types, encodings and small decode helpers of the execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rvx_pkg;

  // Default size of the register file.
  localparam int NumRegsDef = 32;
  // Depth of the queue between the front and the back part.
  localparam int QDepth = 2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TEXT_START = 2'd0;
  localparam logic [1:0] CFG_TEXT_LAST  = 2'd1;
  localparam logic [1:0] CFG_START_PC   = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_WAIT       = 3'd1;
  localparam logic [2:0] ST_ILLEGAL    = 3'd2;
  localparam logic [2:0] ST_UNIMPL     = 3'd3;
  localparam logic [2:0] ST_FETCH      = 3'd4;
  localparam logic [2:0] ST_JALR       = 3'd5;
  localparam logic [2:0] ST_HALTED     = 3'd6;
  localparam logic [2:0] ST_UNEXPECTED = 3'd7;

  // Major opcodes (instruction bits 6:2).
  localparam logic [4:0] OPC_LOAD   = 5'h00;
  localparam logic [4:0] OPC_FENCE  = 5'h03;
  localparam logic [4:0] OPC_OPIMM  = 5'h04;
  localparam logic [4:0] OPC_AUIPC  = 5'h05;
  localparam logic [4:0] OPC_STORE  = 5'h08;
  localparam logic [4:0] OPC_OP     = 5'h0C;
  localparam logic [4:0] OPC_LUI    = 5'h0D;
  localparam logic [4:0] OPC_BRANCH = 5'h18;
  localparam logic [4:0] OPC_JALR   = 5'h19;
  localparam logic [4:0] OPC_JAL    = 5'h1B;
  localparam logic [4:0] OPC_SYSTEM = 5'h1C;

  // ALU funct3 codes.
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;

  // Branch funct3 codes.
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;

  // Multiply funct3 codes.
  localparam logic [2:0] F3_MUL    = 3'd0;
  localparam logic [2:0] F3_MULH   = 3'd1;
  localparam logic [2:0] F3_MULHSU = 3'd2;

  // Funct7 codes.
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_MULD = 7'h01;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // Memory access sizes.
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  // Register use bits returned by the legality check.
  localparam logic [2:0] USE_RD  = 3'b001;
  localparam logic [2:0] USE_RS1 = 3'b010;
  localparam logic [2:0] USE_RS2 = 3'b100;

  // One input item as it sits in the queue.
  typedef struct packed {
    logic        kind;
    logic [31:0] instr_word;
    logic [31:0] load_value;
  } item_t;

  // One result item; the last field sits in the lowest bits.
  typedef struct packed {
    logic [31:0] mem_wdata;
    logic [31:0] mem_addr;
    logic [1:0]  mem_size;
    logic        mem_write;
    logic        mem_read;
    logic [31:0] wb_value;
    logic [4:0]  wb_reg;
    logic        wb_valid;
    logic [31:0] next_pc;
    logic [2:0]  status;
  } result_t;

  localparam int ResultW = $bits(result_t);
  localparam int OutDataW = ((ResultW + 7) / 8) * 8;

  // Register use mask of a legal word, zero when the encoding is illegal.
  function automatic logic [2:0] legal_uses(input logic [31:0] w);
    logic [4:0] op;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [2:0] u;
    op = w[6:2];
    f3 = w[14:12];
    f7 = w[31:25];
    u  = 3'b000;
    case (op)
      OPC_LUI, OPC_AUIPC, OPC_JAL: u = USE_RD;
      OPC_JALR:   u = (f3 == F3_ADD) ? (USE_RD | USE_RS1) : 3'b000;
      OPC_BRANCH: u = (f3 != F3_SLT && f3 != F3_SLTU) ? (USE_RS1 | USE_RS2) : 3'b000;
      OPC_LOAD: begin
        if (f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd2 || f3 == 3'd4 || f3 == 3'd5) begin
          u = USE_RD | USE_RS1;
        end
      end
      OPC_STORE: u = (f3 <= 3'd2) ? (USE_RS1 | USE_RS2) : 3'b000;
      OPC_OPIMM: begin
        if (f3 == F3_SLL) begin
          u = (f7 == F7_BASE) ? (USE_RD | USE_RS1) : 3'b000;
        end else if (f3 == F3_SR) begin
          u = (f7 == F7_BASE || f7 == F7_ALT) ? (USE_RD | USE_RS1) : 3'b000;
        end else begin
          u = USE_RD | USE_RS1;
        end
      end
      OPC_OP: begin
        if (f7 == F7_BASE || f7 == F7_MULD) begin
          u = USE_RD | USE_RS1 | USE_RS2;
        end else if (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR)) begin
          u = USE_RD | USE_RS1 | USE_RS2;
        end
      end
      default: u = 3'b000;
    endcase
    return u;
  endfunction

  // Integer ALU shared by register and immediate forms.
  function automatic logic [31:0] alu(input logic [2:0] f3, input logic alt,
                                      input logic [31:0] a, input logic [31:0] b);
    logic [4:0]  sh;
    logic [31:0] r;
    sh = b[4:0];
    case (f3)
      F3_ADD:  r = alt ? (a - b) : (a + b);
      F3_SLL:  r = a << sh;
      F3_SLT:  r = {31'd0, $signed(a) < $signed(b)};
      F3_SLTU: r = {31'd0, a < b};
      F3_XOR:  r = a ^ b;
      F3_SR:   r = alt ? 32'($signed(a) >>> sh) : (a >> sh);
      F3_OR:   r = a | b;
      default: r = a & b;
    endcase
    return r;
  endfunction

  // Inclusive address range check.
  function automatic logic in_range(input logic [31:0] addr, input logic [31:0] lo,
                                    input logic [31:0] hi);
    return (addr >= lo) && (addr <= hi);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rvx_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rvx_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/rvx_front.sv =====
// ----------------------------------------------------------------------------
// Execute unit front part
// Accepts stream transfers, splits them into items and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module rvx_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_valid_i,
  output logic               s_ready_o,
  input  wire logic [63:0]   s_data_i,
  input  wire logic          s_user_i,
  output rvx_pkg::item_t     head_o,
  output logic               head_vld_o,
  input  wire logic          pop_i
);
  import rvx_pkg::*;

  localparam int PtrW = $clog2(QDepth);
  localparam logic [PtrW:0] Full = (PtrW + 1)'(QDepth);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QDepth - 1);

  item_t           buf_q [QDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [PtrW:0]   cnt_q;
  logic            push, pop;
  item_t           in_item;

  // Field split of the incoming transfer.
  assign in_item.kind       = s_user_i;
  assign in_item.instr_word = s_data_i[31:0];
  assign in_item.load_value = s_data_i[63:32];

  assign s_ready_o  = (cnt_q != Full);
  assign push       = s_valid_i && s_ready_o;
  assign head_vld_o = (cnt_q != '0);
  assign pop        = pop_i && head_vld_o;
  assign head_o     = buf_q[rptr_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wptr_q] <= in_item;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rvx_div.sv =====
// ----------------------------------------------------------------------------
// Execute unit divider
// Radix-2 restoring divider for DIV, DIVU, REM and REMU, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rvx_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        signed_i,
  input  wire logic        rem_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic             done_o,
  output logic [31:0]      res_o
);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [31:0] rem_q, quo_q, den_q, res_q;
  logic        negq_q, negr_q, sel_rem_q;
  logic [31:0] amag, bmag;
  logic [32:0] shifted, diff;
  logic [31:0] rem_d, quo_d, q_fin, r_fin;

  assign amag = (signed_i && a_i[31]) ? (32'd0 - a_i) : a_i;
  assign bmag = (signed_i && b_i[31]) ? (32'd0 - b_i) : b_i;

  // One quotient bit per step.
  always_comb begin
    shifted = {rem_q, quo_q[31]};
    diff    = shifted - {1'b0, den_q};
    if (!diff[32]) begin
      rem_d = diff[31:0];
      quo_d = {quo_q[30:0], 1'b1};
    end else begin
      rem_d = shifted[31:0];
      quo_d = {quo_q[30:0], 1'b0};
    end
    q_fin = negq_q ? (32'd0 - quo_d) : quo_d;
    r_fin = negr_q ? (32'd0 - rem_d) : rem_d;
  end

  // Control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        // A zero divisor and a signed divide by minus one finish at once.
        if (b_i == 32'd0 || (signed_i && b_i == 32'hFFFF_FFFF)) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= '0;
      quo_q     <= amag;
      den_q     <= bmag;
      negq_q    <= signed_i && (a_i[31] ^ b_i[31]);
      negr_q    <= signed_i && a_i[31];
      sel_rem_q <= rem_i;
      if (b_i == 32'd0) begin
        res_q <= rem_i ? a_i : 32'hFFFF_FFFF;
      end else if (signed_i && b_i == 32'hFFFF_FFFF) begin
        res_q <= rem_i ? 32'd0 : (32'd0 - a_i);
      end
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      if (cnt_q == 5'd31) begin
        res_q <= sel_rem_q ? r_fin : q_fin;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

// ===== rtl/rvx_back.sv =====
// ----------------------------------------------------------------------------
// Execute unit back part
// Architectural state, register file, ALU, multiplier and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rvx_back #(
  parameter int NumRegs = rvx_pkg::NumRegsDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rvx_pkg::item_t  head_i,
  input  wire logic            head_vld_i,
  output logic                 pop_o,
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_addr_i,
  input  wire logic [31:0]     cfg_data_i,
  output logic                 out_vld_o,
  output rvx_pkg::result_t     out_o,
  input  wire logic            out_rdy_i
);
  import rvx_pkg::*;

  localparam int IdxW = $clog2(NumRegs);
  localparam logic [5:0] NumRegsW = 6'(NumRegs);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_MUL  = 4'b0100,
    S_DIV  = 4'b1000
  } state_e;

  state_e       state_q, state_d;
  item_t        it_q;
  logic [31:0]  pc_q, pc_d, ts_q, ts_d, tl_q, tl_d;
  logic         halted_q, halted_d, pend_q, pend_d, psgn_q, psgn_d;
  logic [4:0]   pdest_q, pdest_d;
  logic [1:0]   psize_q, psize_d;
  logic [NumRegs-1:0] vld_q;
  result_t      part_q, part_d, out_q, res;
  logic         out_vld_q, fin, pop;
  logic [63:0]  prod_q;

  // Register file ports.
  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  logic [31:0]     wr_data, rd1, rd2;
  logic [4:0]      head_rs1, head_rs2;
  logic [IdxW-1:0] raddr1, raddr2, r1_idx, r2_idx;

  // Decode of the item at work.
  logic [31:0] w, a, b, imm_i, imm_s, imm_b, imm_j, seq, tgt, lv;
  logic [4:0]  op, rd, r1, r2;
  logic [2:0]  f3, uses;
  logic [6:0]  f7;
  logic        wb_en, take, go_mul, go_div;
  logic [31:0] wb_v;
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;

  // Divider hookup.
  logic        div_start, div_done;
  logic [31:0] div_res;

  assign head_rs1 = head_i.instr_word[19:15];
  assign head_rs2 = head_i.instr_word[24:20];
  assign raddr1   = head_rs1[IdxW-1:0];
  assign raddr2   = head_rs2[IdxW-1:0];

  // Two copies of the register file give two read ports.
  rvx_ram #(.Width(32), .Depth(NumRegs)) u_rf_a (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_idx),
    .wdata_i(wr_data),
    .raddr_i(raddr1),
    .rdata_o(rd1)
  );

  rvx_ram #(.Width(32), .Depth(NumRegs)) u_rf_b (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_idx),
    .wdata_i(wr_data),
    .raddr_i(raddr2),
    .rdata_o(rd2)
  );

  // Field extraction and operand selection; unwritten registers read zero.
  assign w      = it_q.instr_word;
  assign op     = w[6:2];
  assign f3     = w[14:12];
  assign f7     = w[31:25];
  assign rd     = w[11:7];
  assign r1     = w[19:15];
  assign r2     = w[24:20];
  assign r1_idx = r1[IdxW-1:0];
  assign r2_idx = r2[IdxW-1:0];
  assign a      = vld_q[r1_idx] ? rd1 : 32'd0;
  assign b      = vld_q[r2_idx] ? rd2 : 32'd0;
  assign imm_i  = {{20{w[31]}}, w[31:20]};
  assign imm_s  = {{20{w[31]}}, w[31:25], w[11:7]};
  assign imm_b  = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign imm_j  = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  assign seq    = pc_q + 32'd4;
  assign tgt    = (a + imm_i) & 32'hFFFF_FFFE;
  assign uses   = legal_uses(w);

  // Multiplier operands; the product is registered before use.
  assign ma = {(f3 == F3_MULH || f3 == F3_MULHSU) ? a[31] : 1'b0, a};
  assign mb = {(f3 == F3_MULH) ? b[31] : 1'b0, b};
  assign mp = ma * mb;

  // Branch condition.
  always_comb begin
    case (f3)
      F3_BEQ:  take = (a == b);
      F3_BNE:  take = (a != b);
      F3_BLT:  take = ($signed(a) < $signed(b));
      F3_BGE:  take = ($signed(a) >= $signed(b));
      F3_BLTU: take = (a < b);
      default: take = (a >= b);
    endcase
  end

  // Load data extension.
  always_comb begin
    case (psize_q)
      SZ_BYTE: lv = psgn_q ? {{24{it_q.load_value[7]}}, it_q.load_value[7:0]}
                           : {24'd0, it_q.load_value[7:0]};
      SZ_HALF: lv = psgn_q ? {{16{it_q.load_value[15]}}, it_q.load_value[15:0]}
                           : {16'd0, it_q.load_value[15:0]};
      default: lv = it_q.load_value;
    endcase
  end

  rvx_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .signed_i(!f3[0]),
    .rem_i   (f3[1]),
    .a_i     (a),
    .b_i     (b),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  // Sequencer and execution.
  always_comb begin
    state_d   = state_q;
    pc_d      = pc_q;
    halted_d  = halted_q;
    pend_d    = pend_q;
    pdest_d   = pdest_q;
    psize_d   = psize_q;
    psgn_d    = psgn_q;
    ts_d      = ts_q;
    tl_d      = tl_q;
    part_d    = part_q;
    res       = '0;
    fin       = 1'b0;
    pop       = 1'b0;
    div_start = 1'b0;
    wr_en     = 1'b0;
    wr_idx    = rd[IdxW-1:0];
    wr_data   = 32'd0;
    wb_en     = 1'b0;
    wb_v      = 32'd0;
    go_mul    = 1'b0;
    go_div    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (head_vld_i && !out_vld_q) begin
          pop     = 1'b1;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_IDLE;
        fin     = 1'b1;
        if (halted_q) begin
          res.status = ST_HALTED;
        end else if (it_q.kind) begin
          if (!pend_q) begin
            res.status = ST_UNEXPECTED;
          end else begin
            // Load data return completes the pending load.
            res.status = ST_OK;
            pend_d     = 1'b0;
            if (pdest_q != 5'd0) begin
              wr_en        = 1'b1;
              wr_idx       = pdest_q[IdxW-1:0];
              wr_data      = lv;
              res.wb_valid = 1'b1;
              res.wb_reg   = pdest_q;
              res.wb_value = lv;
            end
          end
        end else if (pend_q) begin
          res.status = ST_UNEXPECTED;
        end else if (!in_range(pc_q, ts_q, tl_q)) begin
          res.status = ST_FETCH;
          halted_d   = 1'b1;
        end else if (w[1:0] != 2'b11) begin
          res.status = ST_ILLEGAL;
          halted_d   = 1'b1;
        end else if (op == OPC_FENCE || op == OPC_SYSTEM) begin
          res.status = ST_UNIMPL;
          halted_d   = 1'b1;
        end else if (uses == 3'b000 ||
                     (uses[0] && ({1'b0, rd} >= NumRegsW)) ||
                     (uses[1] && ({1'b0, r1} >= NumRegsW)) ||
                     (uses[2] && ({1'b0, r2} >= NumRegsW))) begin
          res.status = ST_ILLEGAL;
          halted_d   = 1'b1;
        end else begin
          res.status = ST_OK;
          pc_d       = seq;
          case (op)
            OPC_LUI: begin
              wb_en = 1'b1;
              wb_v  = {w[31:12], 12'd0};
            end
            OPC_AUIPC: begin
              wb_en = 1'b1;
              wb_v  = pc_q + {w[31:12], 12'd0};
            end
            OPC_OPIMM: begin
              wb_en = 1'b1;
              wb_v  = alu(f3, (f3 == F3_SR) && (f7 == F7_ALT), a, imm_i);
            end
            OPC_OP: begin
              if (f7 == F7_MULD) begin
                if (f3[2]) begin
                  go_div    = 1'b1;
                  div_start = 1'b1;
                end else begin
                  go_mul = 1'b1;
                end
              end else begin
                wb_en = 1'b1;
                wb_v  = alu(f3, f7 == F7_ALT, a, b);
              end
            end
            OPC_JAL: begin
              wb_en = 1'b1;
              wb_v  = seq;
              pc_d  = pc_q + imm_j;
            end
            OPC_JALR: begin
              // A target outside the text range falls through without a link.
              if (!in_range(tgt, ts_q, tl_q)) begin
                res.status = ST_JALR;
              end else begin
                wb_en = 1'b1;
                wb_v  = seq;
                pc_d  = tgt;
              end
            end
            OPC_BRANCH: begin
              if (take) begin
                pc_d = pc_q + imm_b;
              end
            end
            OPC_LOAD: begin
              res.status   = ST_WAIT;
              res.mem_read = 1'b1;
              res.mem_size = f3[1:0];
              res.mem_addr = a + imm_i;
              pend_d       = 1'b1;
              pdest_d      = rd;
              psize_d      = f3[1:0];
              psgn_d       = !f3[2];
            end
            default: begin
              res.mem_write = 1'b1;
              res.mem_size  = f3[1:0];
              res.mem_addr  = a + imm_s;
              case (f3[1:0])
                SZ_BYTE: res.mem_wdata = {24'd0, b[7:0]};
                SZ_HALF: res.mem_wdata = {16'd0, b[15:0]};
                default: res.mem_wdata = b;
              endcase
            end
          endcase
          if (wb_en && rd != 5'd0) begin
            wr_en        = 1'b1;
            wr_data      = wb_v;
            res.wb_valid = 1'b1;
            res.wb_reg   = rd;
            res.wb_value = wb_v;
          end
        end
        res.next_pc = pc_d;

        // Multiply and divide finish in a later cycle.
        if (go_mul || go_div) begin
          fin             = 1'b0;
          part_d          = res;
          part_d.wb_valid = (rd != 5'd0);
          part_d.wb_reg   = (rd != 5'd0) ? rd : 5'd0;
          state_d         = go_mul ? S_MUL : S_DIV;
        end
      end

      S_MUL: begin
        fin     = 1'b1;
        state_d = S_IDLE;
        res     = part_q;
        if (part_q.wb_valid) begin
          wr_en        = 1'b1;
          wr_data      = (f3 == F3_MUL) ? prod_q[31:0] : prod_q[63:32];
          res.wb_value = wr_data;
        end
      end

      S_DIV: begin
        if (div_done) begin
          fin     = 1'b1;
          state_d = S_IDLE;
          res     = part_q;
          if (part_q.wb_valid) begin
            wr_en        = 1'b1;
            wr_data      = div_res;
            res.wb_value = div_res;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase

    // The user must write configuration only while the unit is idle; the block does not enforce it.
    if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_TEXT_START: ts_d = cfg_data_i;
        CFG_TEXT_LAST:  tl_d = cfg_data_i;
        CFG_START_PC: begin
          pc_d     = cfg_data_i;
          halted_d = 1'b0;
          pend_d   = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pc_q      <= '0;
      halted_q  <= 1'b0;
      pend_q    <= 1'b0;
      pdest_q   <= '0;
      psize_q   <= '0;
      psgn_q    <= 1'b0;
      ts_q      <= '0;
      tl_q      <= 32'hFFFF_FFFF;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pc_q     <= pc_d;
      halted_q <= halted_d;
      pend_q   <= pend_d;
      pdest_q  <= pdest_d;
      psize_q  <= psize_d;
      psgn_q   <= psgn_d;
      ts_q     <= ts_d;
      tl_q     <= tl_d;
      if (wr_en) begin
        vld_q[wr_idx] <= 1'b1;
      end
      if (fin) begin
        out_vld_q <= 1'b1;
      end else if (out_rdy_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      it_q <= head_i;
    end
    if (state_q == S_EXEC) begin
      prod_q <= mp[63:0];
    end
    part_q <= part_d;
    if (fin) begin
      out_q <= res;
    end
  end

  assign pop_o     = pop;
  assign out_vld_o = out_vld_q;
  assign out_o     = out_q;

`ifndef SYNTHESIS
  a_fin_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |-> !out_vld_q) else $error("result written over a waiting result");
  a_no_x0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (wr_idx != '0)) else $error("write to x0");
  a_state_1hot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_pop_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (state_q == S_EXEC)) else $error("pop without execute");
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV)) else $error("divider done out of place");
`endif

endmodule

`default_nettype wire

// ===== rtl/rv32im_instruction_execute_unit.sv =====
// ----------------------------------------------------------------------------
// RV32IM instruction execute unit
// Executes RV32IM instruction words and load-data returns, one result each.
// ----------------------------------------------------------------------------
// Every accepted item gives one result transfer. The input side buffers two
// items in a small queue, so transfers are taken while a result waits. The
// execute part handles one item at a time: an item leaves the queue in the
// idle state and its result is registered at the end of the execute state
// that follows. Multiplies also pass through the registered multiplier
// stage. Divides and remainders wait in the divide state while the radix-2
// divider retires one quotient bit a cycle; a zero divisor or a signed divide
// by minus one finishes at once. The next item leaves the queue in the cycle
// after the previous result has been transferred.
// Configuration writes take effect at the clock edge.
`default_nettype none

module rv32im_instruction_execute_unit #(
  parameter int NumRegs = rvx_pkg::NumRegsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // instr_word [31:0], load_value [63:32]
  input  wire logic [63:0]                   s_axis_tdata,
  // kind [0]
  input  wire logic                          s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // status [2:0], next_pc [34:3], wb_valid [35], wb_reg [40:36],
  // wb_value [72:41], mem_read [73], mem_write [74], mem_size [76:75],
  // mem_addr [108:77], mem_wdata [140:109], zero fill above
  output logic [rvx_pkg::OutDataW-1:0]       m_axis_tdata,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_addr_i,
  input  wire logic [31:0]                   cfg_data_i
);
  import rvx_pkg::*;

  item_t   head;
  logic    head_vld, pop;
  result_t res;

  rvx_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .s_user_i  (s_axis_tuser),
    .head_o    (head),
    .head_vld_o(head_vld),
    .pop_i     (pop)
  );

  rvx_back #(.NumRegs(NumRegs)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .head_vld_i(head_vld),
    .pop_o     (pop),
    .cfg_we_i  (cfg_we_i),
    .cfg_addr_i(cfg_addr_i),
    .cfg_data_i(cfg_data_i),
    .out_vld_o (m_axis_tvalid),
    .out_o     (res),
    .out_rdy_i (m_axis_tready)
  );

  assign m_axis_tdata = {{(OutDataW - ResultW){1'b0}}, res};

endmodule

`default_nettype wire
